// File: design/bitmap_handle_allocator_assert.svh
// Assertion macros used by the allocator top level.
`ifndef BITMAP_HANDLE_ALLOCATOR_ASSERT_SVH
`define BITMAP_HANDLE_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define BHA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define BHA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/bha_pkg.sv
// Types and constants shared by the bitmap handle allocator modules.
package bha_pkg;

   localparam int HANDLE_W = 14;
   localparam int STATUS_W = 2;

   localparam logic OP_RESERVE = 1'b0;
   localparam logic OP_FREE    = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 2'd0,
      ST_FULL   = 2'd1,
      ST_DOUBLE = 2'd2,
      ST_RANGE  = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_RSV_READ,
      S_RSV_CHECK,
      S_FREE_MUL,
      S_FREE_QUOT,
      S_FREE_READ,
      S_FREE_CHECK,
      S_RESP
   } state_type;

   typedef struct packed {
      logic       clear_en;
      logic       capture;
      logic       rd_sel_q;
      logic       hint_inc;
      logic       div_mul;
      logic       div_quot;
      logic       div_rem;
      logic       wr_reserve;
      logic       wr_free;
      logic       rsp_load;
      status_type rsp_status;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic map_full;
      logic word_full;
      logic bad_range;
      logic bit_clear;
   } stat_type;

endpackage

// File: design/bha_ctrl.sv
// Allocator controller: sequences clear, reserve scan, free and response.
module bha_ctrl
   import bha_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  logic     req_opcode,
   output logic     req_stall,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type  state_ff, state_in;
   status_type status_ff, status_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         status_ff    <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      cmd          = '0;
      cmd.rsp_status = status_ff;
      state_in     = state_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (stat.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = (req_opcode == OP_FREE) ? S_FREE_MUL : S_RSV_READ;
            end
         end
         S_RSV_READ: begin
            if (stat.map_full) begin
               status_in = ST_FULL;
               state_in  = S_RESP;
            end else begin
               state_in = S_RSV_CHECK;
            end
         end
         S_RSV_CHECK: begin
            if (stat.word_full) begin
               // the word at the hint is full, so move on to the next
               cmd.hint_inc = 1'b1;
               state_in     = S_RSV_READ;
            end else begin
               cmd.wr_reserve = 1'b1;
               status_in      = ST_OK;
               state_in       = S_RESP;
            end
         end
         S_FREE_MUL: begin
            if (stat.bad_range) begin
               status_in = ST_RANGE;
               state_in  = S_RESP;
            end else begin
               cmd.div_mul = 1'b1;
               state_in    = S_FREE_QUOT;
            end
         end
         S_FREE_QUOT: begin
            cmd.div_quot = 1'b1;
            state_in     = S_FREE_READ;
         end
         S_FREE_READ: begin
            cmd.rd_sel_q = 1'b1;
            cmd.div_rem  = 1'b1;
            state_in     = S_FREE_CHECK;
         end
         S_FREE_CHECK: begin
            if (stat.bit_clear) begin
               status_in = ST_DOUBLE;
            end else begin
               cmd.wr_free = 1'b1;
               status_in   = ST_OK;
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: design/bha_dp.sv
// Allocator datapath: used-bit memory, scan hint, handle divide and result register.
module bha_dp
   import bha_pkg::*;
#(
   parameter int WORDS     = 128,
   parameter int WORD_BITS = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_opcode,
   input  logic [HANDLE_W-1:0] req_free_handle,
   input  cmd_type             cmd,
   output stat_type            stat,
   output logic [HANDLE_W-1:0] rsp_granted_handle,
   output logic [STATUS_W-1:0] rsp_status
);

   localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int HW    = AW + 1;
   localparam int BW    = $clog2(WORD_BITS);
   localparam int CAP   = WORDS * WORD_BITS;
   localparam int CAPW  = $clog2(CAP + 1);
   localparam int CMPW  = ((CAPW > HANDLE_W) ? CAPW : HANDLE_W) + 1;
   localparam int SUMW  = ((AW + BW + 2) > HANDLE_W) ? (AW + BW + 2) : HANDLE_W;
   // reciprocal scale; exact for any 14-bit dividend and divisor up to 64
   localparam int K     = 22;
   localparam int RECIP = ((2 ** K) + WORD_BITS - 1) / WORD_BITS;
   localparam int PRODW = HANDLE_W + K;

   logic [WORD_BITS-1:0] mem [WORDS];
   logic [WORD_BITS-1:0] rdata_ff;
   logic                 mem_we;
   logic [AW-1:0]        mem_wa, mem_ra;
   logic [WORD_BITS-1:0] mem_wd;

   logic [AW-1:0]        clr_cnt_ff, clr_cnt_in;
   logic [HW-1:0]        hint_ff, hint_in;
   logic                 op_free_ff;
   logic [HANDLE_W-1:0]  handle_ff;
   logic [PRODW-1:0]     prod_ff;
   logic [AW-1:0]        quot_ff;
   logic [BW-1:0]        rem_ff;
   logic [HANDLE_W-1:0]  grant_ff;
   logic [HANDLE_W-1:0]  rsp_granted_ff;
   status_type           rsp_status_ff;

   logic [HANDLE_W-1:0]  idx;
   logic [SUMW-1:0]      rem_wide;
   logic [WORD_BITS-1:0] low_clear;
   logic [BW-1:0]        bit_idx;
   logic [SUMW-1:0]      grant_sum;
   logic [WORD_BITS-1:0] free_mask;

   assign idx = handle_ff - HANDLE_W'(1);

   // lowest clear bit as a one-hot, then encoded
   assign low_clear = ~rdata_ff & (rdata_ff + WORD_BITS'(1));

   always_comb begin
      bit_idx = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (low_clear[i]) bit_idx = bit_idx | BW'(i);
      end
   end

   assign grant_sum = SUMW'(hint_ff) * SUMW'(WORD_BITS) + SUMW'(bit_idx) + SUMW'(1);
   assign rem_wide  = SUMW'(idx) - SUMW'(quot_ff) * SUMW'(WORD_BITS);
   assign free_mask = WORD_BITS'(1) << rem_ff;

   always_comb begin
      mem_we = 1'b0;
      mem_wa = hint_ff[AW-1:0];
      mem_wd = rdata_ff | low_clear;
      if (cmd.clear_en) begin
         mem_we = 1'b1;
         mem_wa = clr_cnt_ff;
         mem_wd = '0;
      end else if (cmd.wr_reserve) begin
         mem_we = 1'b1;
      end else if (cmd.wr_free) begin
         mem_we = 1'b1;
         mem_wa = quot_ff;
         mem_wd = rdata_ff & ~free_mask;
      end
   end

   assign mem_ra = cmd.rd_sel_q ? quot_ff : hint_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      rdata_ff <= mem[mem_ra];
   end

   always_comb begin
      clr_cnt_in = clr_cnt_ff;
      if (cmd.clear_en) clr_cnt_in = clr_cnt_ff + AW'(1);
      hint_in = hint_ff;
      if (cmd.hint_inc) begin
         hint_in = hint_ff + HW'(1);
      end else if (cmd.wr_free && (HW'(quot_ff) < hint_ff)) begin
         hint_in = HW'(quot_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
         hint_ff    <= '0;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
         hint_ff    <= hint_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_free_ff <= req_opcode;
         handle_ff  <= req_free_handle;
      end
      if (cmd.div_mul)    prod_ff  <= PRODW'(idx) * PRODW'(RECIP);
      if (cmd.div_quot)   quot_ff  <= prod_ff[K +: AW];
      if (cmd.div_rem)    rem_ff   <= rem_wide[BW-1:0];
      if (cmd.wr_reserve) grant_ff <= grant_sum[HANDLE_W-1:0];
      if (cmd.rsp_load) begin
         rsp_status_ff  <= cmd.rsp_status;
         rsp_granted_ff <= (cmd.rsp_status == ST_OK && op_free_ff == OP_RESERVE) ?
                           grant_ff : '0;
      end
   end

   assign stat.clear_last = (clr_cnt_ff == AW'(WORDS - 1));
   assign stat.map_full   = (hint_ff == HW'(WORDS));
   assign stat.word_full  = (rdata_ff == {WORD_BITS{1'b1}});
   assign stat.bad_range  = (handle_ff == '0) || (CMPW'(handle_ff) > CMPW'(CAP));
   assign stat.bit_clear  = ~rdata_ff[rem_ff];

   assign rsp_granted_handle = rsp_granted_ff;
   assign rsp_status         = rsp_status_ff;

endmodule

// File: design/bitmap_handle_allocator.sv
// Bitmap first-fit handle allocator, top level.
// Keeps a used-bit map of WORDS words of WORD_BITS bits in one memory with a
// registered read port. After reset a clearing pass writes one word per cycle,
// during which no item is taken. A reserve item reads the word at the scan hint
// and steps past each full word, then marks the lowest clear bit, or answers full
// once the hint passes the last word; the scan starts at a hint that stays at the
// first word that may have a clear bit, so skipped words are paid for once between
// frees. A free item passes through reciprocal multiply, quotient, memory read
// with remainder, check and write, and result load; a free whose handle is zero
// or beyond capacity goes straight to the result load. One item is in work at a
// time; the next is accepted once the result enters the output register, which
// holds it while the result side stalls. Handles are 1-based; 0 means none.
`include "bitmap_handle_allocator_assert.svh"

module bitmap_handle_allocator
   import bha_pkg::*;
#(
   parameter int WORDS     = 128,
   parameter int WORD_BITS = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_opcode,
   input  logic [HANDLE_W-1:0] req_free_handle,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [HANDLE_W-1:0] rsp_granted_handle,
   output logic [STATUS_W-1:0] rsp_status
);

   cmd_type  cmd;
   stat_type stat;

   bha_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .stat       (stat),
      .cmd        (cmd)
   );

   bha_dp #(
      .WORDS     (WORDS),
      .WORD_BITS (WORD_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_opcode         (req_opcode),
      .req_free_handle    (req_free_handle),
      .cmd                (cmd),
      .stat               (stat),
      .rsp_granted_handle (rsp_granted_handle),
      .rsp_status         (rsp_status)
   );

   `BHA_ASSERT_NOW(a_no_grant_on_error, rsp_valid && (rsp_status != ST_OK), rsp_granted_handle == '0, "error result carries a handle")
   `BHA_ASSERT_NOW(a_stall_while_clear, cmd.clear_en, req_stall, "item accepted during clearing pass")
   `BHA_ASSERT_NOW(a_single_write, cmd.wr_reserve || cmd.wr_free, !cmd.clear_en && !(cmd.wr_reserve && cmd.wr_free), "conflicting map writes")
   `BHA_ASSERT_NEXT(a_load_sets_valid, cmd.rsp_load, rsp_valid, "loaded result not presented")

endmodule

// File: dv/bitmap_handle_allocator_checker.sv
// Result checker for the bitmap handle allocator: tracks the used map, predicts, compares.
`timescale 1ns / 1ps

module bitmap_handle_allocator_checker
   import bha_pkg::*;
#(
   parameter int WORDS     = 128,
   parameter int WORD_BITS = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic                req_opcode,
   input  logic [HANDLE_W-1:0] req_free_handle,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [HANDLE_W-1:0] rsp_granted_handle,
   input  logic [STATUS_W-1:0] rsp_status,
   output int                  mismatch_count,
   output int                  results_pending
);

   typedef struct packed {
      logic [HANDLE_W-1:0] handle;
      status_type          status;
   } grant_type;

   logic [WORD_BITS-1:0] used_words [WORDS];
   grant_type            pending_grants [$];

   // First-fit: lowest word that is not full, lowest clear bit in it.
   function automatic grant_type alloc_lowest_free();
      grant_type r;
      r.handle = '0;
      r.status = ST_FULL;
      for (int w = 0; w < WORDS; w++) begin
         if (used_words[w] != '1) begin
            for (int b = 0; b < WORD_BITS; b++) begin
               if (!used_words[w][b]) begin
                  used_words[w][b] = 1'b1;
                  r.handle = HANDLE_W'(w * WORD_BITS + b + 1);
                  r.status = ST_OK;
                  return r;
               end
            end
         end
      end
      return r;
   endfunction

   function automatic grant_type release_handle(input logic [HANDLE_W-1:0] h);
      grant_type r;
      int        idx;
      r.handle = '0;
      if (h == '0 || int'(h) > WORDS * WORD_BITS) begin
         r.status = ST_RANGE;
      end else begin
         idx = int'(h) - 1;
         if (!used_words[idx / WORD_BITS][idx % WORD_BITS]) begin
            r.status = ST_DOUBLE;
         end else begin
            used_words[idx / WORD_BITS][idx % WORD_BITS] = 1'b0;
            r.status = ST_OK;
         end
      end
      return r;
   endfunction

   task automatic flag_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t: %s; got handle %0d status %0d", $time, what,
                  rsp_granted_handle, rsp_status);
   endtask

   // Everything is driven at the rising edge, so the falling edge sees stable
   // values; a handshake seen here completes at the next rising edge.
   always @(negedge clock) begin : watch
      grant_type want;
      if (reset) begin
         for (int w = 0; w < WORDS; w++)
            used_words[w] = '0;
         pending_grants.delete();
      end else begin
         // result first: it always belongs to an older item
         if (rsp_valid && !rsp_stall) begin
            if (pending_grants.size() == 0) begin
               flag_mismatch("result with no item outstanding");
            end else begin
               want = pending_grants.pop_front();
               if (rsp_granted_handle !== want.handle || rsp_status !== want.status)
                  flag_mismatch($sformatf("result differs: expected handle %0d status %s",
                                          want.handle, want.status.name()));
            end
         end
         if (req_valid && !req_stall) begin
            if (req_opcode == OP_RESERVE)
               pending_grants.push_back(alloc_lowest_free());
            else
               pending_grants.push_back(release_handle(req_free_handle));
         end
      end
      results_pending = pending_grants.size();
   end

endmodule

// File: dv/bitmap_handle_allocator_test.sv
// Testbench top for the bitmap handle allocator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module bitmap_handle_allocator_test;
   import bha_pkg::*;

   localparam int MAP_WORDS     = 128;
   localparam int MAP_WORD_BITS = 64;
   localparam int CAPACITY      = MAP_WORDS * MAP_WORD_BITS;

   logic                clock;
   logic                reset           = 1'b1;
   logic                req_valid       = 1'b0;
   logic                req_stall;
   logic                req_opcode      = OP_RESERVE;
   logic [HANDLE_W-1:0] req_free_handle = '0;
   logic                rsp_valid;
   logic                rsp_stall       = 1'b0;
   logic [HANDLE_W-1:0] rsp_granted_handle;
   logic [STATUS_W-1:0] rsp_status;

   int                  mismatch_count;
   int                  results_pending;
   logic                steady = 1'b0;    // no idling on either side while set
   logic [HANDLE_W-1:0] live_handles [$];
   logic [HANDLE_W-1:0] last_freed = '0;

   bitmap_handle_allocator #(
      .WORDS     (MAP_WORDS),
      .WORD_BITS (MAP_WORD_BITS)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_opcode         (req_opcode),
      .req_free_handle    (req_free_handle),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_granted_handle (rsp_granted_handle),
      .rsp_status         (rsp_status)
   );

   bitmap_handle_allocator_checker #(
      .WORDS     (MAP_WORDS),
      .WORD_BITS (MAP_WORD_BITS)
   ) checker_inst (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_opcode         (req_opcode),
      .req_free_handle    (req_free_handle),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_granted_handle (rsp_granted_handle),
      .rsp_status         (rsp_status),
      .mismatch_count     (mismatch_count),
      .results_pending    (results_pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= !reset && !steady && ($urandom_range(99) < 36);
   end

   // Granted handles feed later well-formed frees.
   always @(negedge clock) begin
      if (!reset && rsp_valid && !rsp_stall && rsp_status == ST_OK &&
          rsp_granted_handle != '0)
         live_handles.push_back(rsp_granted_handle);
   end

   task automatic send_item(input logic op, input logic [HANDLE_W-1:0] h);
      while (!steady && $urandom_range(99) < 36) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_free_handle <= h;
      @(negedge clock);
      while (req_stall) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic reserve_one();
      send_item(OP_RESERVE, HANDLE_W'($urandom));    // handle field is ignored
   endtask

   task automatic free_live();
      int                  slot;
      logic [HANDLE_W-1:0] h;
      slot = $urandom_range(live_handles.size() - 1);
      h = live_handles[slot];
      live_handles.delete(slot);
      last_freed = h;
      send_item(OP_FREE, h);
   endtask

   // Stray frees: repeat of the last freed handle, zero, or a random one, often out of range.
   task automatic free_stray();
      case ($urandom_range(3))
         0:       send_item(OP_FREE, last_freed);
         1:       send_item(OP_FREE, '0);
         default: send_item(OP_FREE, HANDLE_W'($urandom_range(16383)));
      endcase
   endtask

   task automatic wait_drained();
      while (results_pending != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      int pick;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: first fit, refill of a hole, double free, range edges
      repeat (3) send_item(OP_RESERVE, '0);
      send_item(OP_FREE, HANDLE_W'(2));
      send_item(OP_RESERVE, '0);
      send_item(OP_FREE, HANDLE_W'(2));
      send_item(OP_FREE, HANDLE_W'(2));
      send_item(OP_FREE, '0);
      send_item(OP_FREE, HANDLE_W'(CAPACITY + 1));
      send_item(OP_FREE, '1);
      send_item(OP_FREE, HANDLE_W'(CAPACITY));
      send_item(OP_RESERVE, '1);
      send_item(OP_FREE, HANDLE_W'(1));
      send_item(OP_FREE, HANDLE_W'(2));
      send_item(OP_FREE, HANDLE_W'(3));
      req_valid <= 1'b0;
      wait_drained();
      live_handles.delete();    // map is empty again

      // random mix: grows the map in the first half, shrinks it in the second
      for (int n = 0; n < 1080; n++) begin
         steady <= (n >= 400 && n < 700);
         pick = $urandom_range(99);
         if (pick < 12)
            free_stray();
         else if (pick < (n < 540 ? 40 : 70) && live_handles.size() != 0)
            free_live();
         else
            reserve_one();
      end
      req_valid <= 1'b0;
      steady    <= 1'b0;
      wait_drained();

      // churn, last handle included
      send_item(OP_FREE, HANDLE_W'(CAPACITY));
      send_item(OP_RESERVE, '0);
      for (int n = 0; n < 200; n++) begin
         pick = $urandom_range(99);
         if (pick < 45 && live_handles.size() != 0)
            free_live();
         else if (pick < 88)
            reserve_one();
         else
            free_stray();
      end
      req_valid <= 1'b0;
      wait_drained();
      repeat (16) @(posedge clock);

      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
